### hw/rtl/dtns_pkg.sv
// ----------------------------------------------------------------------------
// dtns_pkg
// Shared types, codes and default sizes of the document similarity engine.
// ----------------------------------------------------------------------------
package dtns_pkg;

   localparam int DEF_MAX_WORDS  = 256;
   localparam int DEF_MAX_DOCS   = 64;
   localparam int DEF_COUNT_BITS = 16;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_WORDS = 1'b0;
   localparam logic CSR_IDX_DOCS  = 1'b1;

   localparam logic [8:0] WORDS_RESET = 9'd256;
   localparam logic [6:0] DOCS_RESET  = 7'd64;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_RANGE   = 2'd1;
   localparam logic [1:0] STAT_ORDER   = 2'd2;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  word_row;
      logic [5:0]  doc_first;
      logic [5:0]  doc_second;
      logic [15:0] occ_count;
   } req_type;

   typedef struct packed {
      logic [31:0] similarity;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WIPE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_Q_COLA,
      ST_Q_COLB,
      ST_Q_CHK,
      ST_ROW_RD,
      ST_ROW_CAP,
      ST_DIV_A,
      ST_DIV_B,
      ST_ACC,
      ST_DIV_S1,
      ST_DIV_S2
   } state_type;

endpackage

### hw/rtl/dtns_divider.sv
// ----------------------------------------------------------------------------
// dtns_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtns_divider import dtns_pkg::*; #(
   parameter int QW = 41,
   parameter int DW = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       div_start,
   input  logic [DW-1:0]              rem_init,
   input  logic [QW-1:0]              num_init,
   input  logic [$clog2(QW+1)-1:0]    steps,
   input  logic [DW-1:0]              den,
   output logic [QW-1:0]              quot,
   output div_stat_type               stat
);

   localparam int CW = $clog2(QW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [QW-1:0] num_ff, num_in;
   logic [QW-1:0] quot_ff, quot_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          fits;

   // remainder stays below the divisor, so the trial is one bit wider
   always_comb begin
      trial = {rem_ff, num_ff[QW-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
   end

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_start) begin
         rem_in  = rem_init;
         num_in  = num_init;
         quot_in = '0;
         den_in  = den;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DW-1:0] : trial[DW-1:0];
         num_in  = {num_ff[QW-2:0], 1'b0};
         quot_in = {quot_ff[QW-2:0], fits};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   assign quot      = quot_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a run");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !busy_ff)
      else $error("divider started while running");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider running with no steps left");

endmodule

### hw/rtl/doc_term_normalized_similarity.sv
// ----------------------------------------------------------------------------
// doc_term_normalized_similarity
// Word-by-document count store with normalized pair similarity queries.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; every command gives
// exactly one result on rsp_item, marked by rsp_valid for one cycle, and the
// receiver cannot stall it. An add passes through a row read state and a write
// state; func 3 and rejected commands are answered from idle. A clear, and the
// wipe after reset, sweep the memories one row a cycle over max(MAX_WORDS,
// MAX_DOCS) addresses (256 by default) with busy high. A query runs on the
// shared bit-serial divider: two 33-step divisions per word row with a nonzero
// total, then two wide divisions of 33 + log2(MAX_WORDS) steps at the end.
// ----------------------------------------------------------------------------
module doc_term_normalized_similarity import dtns_pkg::*; #(
   parameter int MAX_WORDS  = DEF_MAX_WORDS,
   parameter int MAX_DOCS   = DEF_MAX_DOCS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  req_type                  req_item,
   output logic                     busy,
   output logic                     rsp_valid,
   output rsp_type                  rsp_item,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int CB   = COUNT_BITS;
   localparam int RIW  = $clog2(MAX_WORDS);
   localparam int DIW  = $clog2(MAX_DOCS);
   localparam int RTW  = CB + DIW;
   localparam int CTW  = CB + RIW;
   localparam int DW   = (RTW > CTW) ? RTW : CTW;
   localparam int SW   = 33 + RIW;
   localparam int QW   = SW;
   localparam int STW  = $clog2(QW + 1);
   localparam int LIMW = ($clog2(MAX_WORDS + 1) > 9) ? $clog2(MAX_WORDS + 1) : 9;
   localparam int DLW  = ($clog2(MAX_DOCS + 1) > 7) ? $clog2(MAX_DOCS + 1) : 7;
   localparam int RW   = MAX_DOCS * CB;
   localparam int AW   = ((CB > 16) ? CB : 16) + 1;
   localparam int WIPE_LEN = (MAX_WORDS > MAX_DOCS) ? MAX_WORDS : MAX_DOCS;
   localparam int WPW  = $clog2(WIPE_LEN);

   localparam logic [AW-1:0]  CELL_MAX   = AW'({CB{1'b1}});
   localparam logic [STW-1:0] FRAC_STEPS = STW'(33);
   localparam logic [STW-1:0] SUM_STEPS  = STW'(SW);

   // memories
   logic [RW-1:0]  row_mem  [MAX_WORDS];
   logic [RTW-1:0] rtot_mem [MAX_WORDS];
   logic [CTW-1:0] col_mem  [MAX_DOCS];
   logic [RW-1:0]  row_rd_ff;
   logic [RTW-1:0] rtot_rd_ff;
   logic [CTW-1:0] col_rd_ff;

   logic [RIW-1:0] row_raddr, row_waddr;
   logic [DIW-1:0] col_raddr, col_waddr;
   logic           row_we, rtot_we, col_we;
   logic [RW-1:0]  row_wdata;
   logic [RTW-1:0] rtot_wdata;
   logic [CTW-1:0] col_wdata;

   state_type state_ff, state_in;

   req_type       item_ff, item_in;
   logic [8:0]    wiu_ff;
   logic [6:0]    diu_ff;
   logic [SW-1:0] s_ff, s_in;
   logic [CTW-1:0] cola_ff, cola_in, colb_ff, colb_in;
   logic [CB-1:0] cella_ff, cella_in, cellb_ff, cellb_in;
   logic [RTW-1:0] rtot_ff, rtot_in;
   logic [31:0]   qa_ff, qa_in;
   logic [63:0]   prod_ff, prod_in;
   logic [LIMW-1:0] row_ff, row_in;
   logic [WPW-1:0] wipe_ff, wipe_in;
   logic          wipe_rsp_ff, wipe_rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [LIMW-1:0] wlim;
   logic [DLW-1:0]  dlim;
   logic            accept;
   logic            add_bad, q_bad_range, q_unordered;
   logic [DIW-1:0]  a_idx, b_idx;
   logic [CB-1:0]   cell_old, delta;
   logic [AW-1:0]   cell_sum;
   logic [CB-1:0]   cell_new;
   logic            rows_done, wipe_last;

   logic            div_start;
   logic [DW-1:0]   div_rem, div_den;
   logic [QW-1:0]   div_num, div_quot;
   logic [STW-1:0]  div_steps;
   div_stat_type    div_stat;

   dtns_divider #(
      .QW (QW),
      .DW (DW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .rem_init  (div_rem),
      .num_init  (div_num),
      .steps     (div_steps),
      .den       (div_den),
      .quot      (div_quot),
      .stat      (div_stat)
   );

   // configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_IDX_DOCS) ? CSR_DATA_BITS'(diu_ff)
                                              : CSR_DATA_BITS'(wiu_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wiu_ff <= WORDS_RESET;
         diu_ff <= DOCS_RESET;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2] == CSR_IDX_DOCS) begin
            diu_ff <= pwdata[6:0];
         end else begin
            wiu_ff <= pwdata[8:0];
         end
      end
   end

   always_comb begin
      wlim = (LIMW'(wiu_ff) < LIMW'(MAX_WORDS)) ? LIMW'(wiu_ff) : LIMW'(MAX_WORDS);
      dlim = (DLW'(diu_ff) < DLW'(MAX_DOCS)) ? DLW'(diu_ff) : DLW'(MAX_DOCS);
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      add_bad     = (LIMW'(req_item.word_row) >= wlim) ||
                    (DLW'(req_item.doc_first) >= dlim);
      q_bad_range = (DLW'(req_item.doc_first) >= dlim) ||
                    (DLW'(req_item.doc_second) >= dlim);
      q_unordered = req_item.doc_first >= req_item.doc_second;
   end

   always_comb begin
      a_idx     = DIW'(item_ff.doc_first);
      b_idx     = DIW'(item_ff.doc_second);
      cell_old  = row_rd_ff[a_idx*CB +: CB];
      cell_sum  = AW'(cell_old) + AW'(item_ff.occ_count);
      cell_new  = (cell_sum > CELL_MAX) ? CB'(CELL_MAX) : CB'(cell_sum);
      delta     = cell_new - cell_old;
      rows_done = row_ff >= wlim;
      wipe_last = wipe_ff == WPW'(WIPE_LEN - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_item.func)
                  FUNC_ADD:   state_in = add_bad ? ST_IDLE : ST_ADD_RD;
                  FUNC_QUERY: state_in = (q_bad_range || q_unordered) ? ST_IDLE
                                                                       : ST_Q_COLA;
                  FUNC_CLEAR: state_in = ST_WIPE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_WIPE:    state_in = wipe_last ? ST_IDLE : ST_WIPE;
         ST_ADD_RD:  state_in = ST_ADD_WR;
         ST_ADD_WR:  state_in = ST_IDLE;
         ST_Q_COLA:  state_in = ST_Q_COLB;
         ST_Q_COLB:  state_in = ST_Q_CHK;
         ST_Q_CHK:   state_in = (cola_ff == '0 || col_rd_ff == '0) ? ST_IDLE : ST_ROW_RD;
         ST_ROW_RD:  state_in = rows_done ? ST_DIV_S1 : ST_ROW_CAP;
         ST_ROW_CAP: state_in = (rtot_rd_ff == '0) ? ST_ROW_RD : ST_DIV_A;
         ST_DIV_A:   state_in = div_stat.done ? ST_DIV_B : ST_DIV_A;
         ST_DIV_B:   state_in = div_stat.done ? ST_ACC : ST_DIV_B;
         ST_ACC:     state_in = ST_ROW_RD;
         ST_DIV_S1:  state_in = div_stat.done ? ST_DIV_S2 : ST_DIV_S1;
         ST_DIV_S2:  state_in = div_stat.done ? ST_IDLE : ST_DIV_S2;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      item_in      = item_ff;
      s_in         = s_ff;
      cola_in      = cola_ff;
      colb_in      = colb_ff;
      cella_in     = cella_ff;
      cellb_in     = cellb_ff;
      rtot_in      = rtot_ff;
      qa_in        = qa_ff;
      prod_in      = prod_ff;
      row_in       = row_ff;
      wipe_in      = wipe_ff;
      wipe_rsp_in  = wipe_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      row_raddr  = RIW'(item_ff.word_row);
      col_raddr  = a_idx;
      row_waddr  = RIW'(item_ff.word_row);
      col_waddr  = a_idx;
      row_we     = 1'b0;
      rtot_we    = 1'b0;
      col_we     = 1'b0;
      row_wdata  = row_rd_ff;
      row_wdata[a_idx*CB +: CB] = cell_new;
      rtot_wdata = rtot_rd_ff + RTW'(delta);
      col_wdata  = col_rd_ff + CTW'(delta);

      div_start = 1'b0;
      div_rem   = DW'(cella_ff >> 1);
      div_num   = QW'({cella_ff[0], 32'd0}) << (QW - 33);
      div_steps = FRAC_STEPS;
      div_den   = DW'(rtot_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = req_item;
               rsp_in  = '{similarity: 32'd0, status: STAT_OK};
               unique case (req_item.func)
                  FUNC_ADD: begin
                     if (add_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STAT_RANGE;
                     end
                  end
                  FUNC_QUERY: begin
                     if (q_bad_range) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STAT_RANGE;
                     end else if (q_unordered) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STAT_ORDER;
                     end
                  end
                  FUNC_CLEAR: begin
                     wipe_in     = '0;
                     wipe_rsp_in = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_WIPE: begin
            row_waddr  = RIW'(wipe_ff);
            col_waddr  = DIW'(wipe_ff);
            row_wdata  = '0;
            rtot_wdata = '0;
            col_wdata  = '0;
            row_we     = {1'b0, wipe_ff} < (WPW+1)'(MAX_WORDS);
            rtot_we    = row_we;
            col_we     = {1'b0, wipe_ff} < (WPW+1)'(MAX_DOCS);
            wipe_in    = wipe_ff + WPW'(1);
            if (wipe_last) begin
               rsp_valid_in = wipe_rsp_ff;
               rsp_in       = '{similarity: 32'd0, status: STAT_OK};
            end
         end
         ST_ADD_RD: ;
         ST_ADD_WR: begin
            row_we       = 1'b1;
            rtot_we      = 1'b1;
            col_we       = 1'b1;
            rsp_valid_in = 1'b1;
         end
         ST_Q_COLA: ;
         ST_Q_COLB: begin
            col_raddr = b_idx;
            cola_in   = col_rd_ff;
         end
         ST_Q_CHK: begin
            colb_in = col_rd_ff;
            s_in    = '0;
            row_in  = '0;
            if (cola_ff == '0 || col_rd_ff == '0) begin
               rsp_valid_in = 1'b1;
            end
         end
         ST_ROW_RD: begin
            row_raddr = RIW'(row_ff);
            if (rows_done) begin
               div_start = 1'b1;
               div_rem   = '0;
               div_num   = QW'(s_ff) << (QW - SW);
               div_steps = SUM_STEPS;
               div_den   = DW'(cola_ff);
            end
         end
         ST_ROW_CAP: begin
            cella_in = row_rd_ff[a_idx*CB +: CB];
            cellb_in = row_rd_ff[b_idx*CB +: CB];
            rtot_in  = rtot_rd_ff;
            if (rtot_rd_ff == '0) begin
               row_in = row_ff + LIMW'(1);
            end else begin
               // first fraction: count of document a over the row total
               div_start = 1'b1;
               div_rem   = DW'(row_rd_ff[a_idx*CB +: CB] >> 1);
               div_num   = QW'({row_rd_ff[a_idx*CB], 32'd0}) << (QW - 33);
               div_den   = DW'(rtot_rd_ff);
            end
         end
         ST_DIV_A: begin
            if (div_stat.done) begin
               qa_in     = div_quot[31:0];
               div_start = 1'b1;
               div_rem   = DW'(cellb_ff >> 1);
               div_num   = QW'({cellb_ff[0], 32'd0}) << (QW - 33);
            end
         end
         ST_DIV_B: begin
            // a full-scale fraction forces the other to zero, so 32 bits suffice
            if (div_stat.done) begin
               prod_in = qa_ff * div_quot[31:0];
            end
         end
         ST_ACC: begin
            s_in   = s_ff + SW'(prod_ff[63:32]);
            row_in = row_ff + LIMW'(1);
         end
         ST_DIV_S1: begin
            if (div_stat.done) begin
               div_start = 1'b1;
               div_rem   = '0;
               div_num   = div_quot << (QW - SW);
               div_steps = SUM_STEPS;
               div_den   = DW'(colb_ff);
            end
         end
         ST_DIV_S2: begin
            if (div_stat.done) begin
               rsp_valid_in      = 1'b1;
               rsp_in.similarity = (|div_quot[QW-1:32]) ? 32'hFFFF_FFFF
                                                        : div_quot[31:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         wipe_ff      <= '0;
         wipe_rsp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wipe_ff      <= wipe_in;
         wipe_rsp_ff  <= wipe_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff  <= item_in;
      s_ff     <= s_in;
      cola_ff  <= cola_in;
      colb_ff  <= colb_in;
      cella_ff <= cella_in;
      cellb_ff <= cellb_in;
      rtot_ff  <= rtot_in;
      qa_ff    <= qa_in;
      prod_ff  <= prod_in;
      row_ff   <= row_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      row_rd_ff <= row_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (rtot_we) begin
         rtot_mem[row_waddr] <= rtot_wdata;
      end
      rtot_rd_ff <= rtot_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_mem[col_waddr] <= col_wdata;
      end
      col_rd_ff <= col_mem[col_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_IDLE)
      else $error("result beat while still working");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != STAT_OK |-> rsp_item.similarity == 32'd0)
      else $error("rejected command with nonzero similarity");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy without a command");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV_A || state_ff == ST_DIV_B ||
                        state_ff == ST_DIV_S1 || state_ff == ST_DIV_S2)
      else $error("divider finished outside a wait state");

endmodule

### dv/doc_term_normalized_similarity_chk.sv
// ----------------------------------------------------------------------------
// doc_term_normalized_similarity_chk
// Watches the command, result and register ports of the similarity engine,
// keeps its own count store and totals, and compares every result beat in
// order with the value that store gives.
// ----------------------------------------------------------------------------
module doc_term_normalized_similarity_chk import dtns_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  req_type                  req_item,
   input  logic                     rsp_valid,
   input  rsp_type                  rsp_item,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic                     pready,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output int                       fail_count,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_WORDS = DEF_MAX_WORDS;
   localparam int N_DOCS  = DEF_MAX_DOCS;

   logic [15:0] cell_count [N_WORDS][N_DOCS];
   logic [31:0] word_sum [N_WORDS];
   logic [31:0] doc_sum [N_DOCS];
   logic [8:0]  words_cfg;
   logic [6:0]  docs_cfg;
   rsp_type     expected_rsp [$];

   assign pending = expected_rsp.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic void wipe_store();
      for (int r = 0; r < N_WORDS; r++) begin
         word_sum[r] = '0;
         for (int d = 0; d < N_DOCS; d++) cell_count[r][d] = '0;
      end
      for (int d = 0; d < N_DOCS; d++) doc_sum[d] = '0;
   endfunction

   function automatic rsp_type predict_similarity(input req_type it);
      int          wl;
      int          dl;
      logic [16:0] sum17;
      logic [15:0] added;
      logic [65:0] qa;
      logic [65:0] qb;
      logic [65:0] prod;
      logic [63:0] acc;
      rsp_type     r;
      wl = (words_cfg > N_WORDS) ? N_WORDS : int'(words_cfg);
      dl = (docs_cfg > N_DOCS) ? N_DOCS : int'(docs_cfg);
      r = '0;
      case (it.func)
         FUNC_ADD: begin
            if (it.word_row >= wl || it.doc_first >= dl) begin
               r.status = STAT_RANGE;
            end else begin
               sum17 = cell_count[it.word_row][it.doc_first] + it.occ_count;
               if (sum17 > 17'hFFFF) sum17 = 17'hFFFF;
               added = sum17[15:0] - cell_count[it.word_row][it.doc_first];
               cell_count[it.word_row][it.doc_first] = sum17[15:0];
               word_sum[it.word_row] += added;
               doc_sum[it.doc_first] += added;
            end
         end
         FUNC_QUERY: begin
            if (it.doc_first >= dl || it.doc_second >= dl) begin
               r.status = STAT_RANGE;
            end else if (it.doc_first >= it.doc_second) begin
               r.status = STAT_ORDER;
            end else if (doc_sum[it.doc_first] != 0 && doc_sum[it.doc_second] != 0) begin
               acc = '0;
               for (int w = 0; w < wl; w++) begin
                  if (word_sum[w] != 0) begin
                     qa = ({50'b0, cell_count[w][it.doc_first]} << 32) / word_sum[w];
                     qb = ({50'b0, cell_count[w][it.doc_second]} << 32) / word_sum[w];
                     prod = qa * qb;
                     acc += prod[65:32];
                  end
               end
               acc = acc / doc_sum[it.doc_first];
               acc = acc / doc_sum[it.doc_second];
               r.similarity = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            end
         end
         FUNC_CLEAR: wipe_store();
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         wipe_store();
         words_cfg = WORDS_RESET;
         docs_cfg  = DOCS_RESET;
         fail_count = 0;
         expected_rsp.delete();
      end else begin
         // the older expectation is retired before a new command is predicted
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch("unexpected result beat", rsp_item.similarity, 0);
            end else begin
               rsp_type want;
               want = expected_rsp.pop_front();
               if (rsp_item.similarity !== want.similarity)
                  report_mismatch("similarity", rsp_item.similarity, want.similarity);
               if (rsp_item.status !== want.status)
                  report_mismatch("status", rsp_item.status, want.status);
            end
         end
         if (start && !busy) expected_rsp = {expected_rsp, predict_similarity(req_item)};
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == CSR_IDX_WORDS) words_cfg = pwdata[8:0];
            else docs_cfg = pwdata[6:0];
         end
      end
   end

endmodule

### dv/doc_term_normalized_similarity_tb.sv
// ----------------------------------------------------------------------------
// doc_term_normalized_similarity_tb
// Drives directed and random add, query, clear and invalid commands through
// several register settings, with random gaps between beats in all but the
// last phase; the checker beside the engine predicts and compares each result.
// ----------------------------------------------------------------------------
module doc_term_normalized_similarity_tb import dtns_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 3_000_000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   req_type                  req_item = '0;
   logic                     busy;
   logic                     rsp_valid;
   rsp_type                  rsp_item;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;
   int                       fail_count;
   int                       pending;
   int                       cycles = 0;
   int                       sent = 0;
   int                       received = 0;
   int                       n_add = 0;
   int                       n_query = 0;
   int                       n_clear = 0;
   bit                       gaps_on = 1'b1;
   int                       words_now = 256;
   int                       docs_now = 64;

   always #2 clock = ~clock;

   doc_term_normalized_similarity u_dut (
      .clock, .reset, .start, .req_item, .busy, .rsp_valid, .rsp_item,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   doc_term_normalized_similarity_chk u_chk (
      .clock, .reset, .start, .busy, .req_item, .rsp_valid, .rsp_item,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending
   );

   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid) received++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("doc_term_normalized_similarity_tb: FAIL");
         $finish;
      end
   end

   // start stays high between back-to-back beats
   task automatic send_cmd(input req_type it);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      sent++;
      case (it.func)
         FUNC_ADD:   n_add++;
         FUNC_QUERY: n_query++;
         FUNC_CLEAR: n_clear++;
         default: ;
      endcase
   endtask

   task automatic cmd(input logic [1:0] f, input int row, input int a, input int b,
                      input int cnt);
      req_type it;
      it.func       = f;
      it.word_row   = row[7:0];
      it.doc_first  = a[5:0];
      it.doc_second = b[5:0];
      it.occ_count  = cnt[15:0];
      send_cmd(it);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (received != sent) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input int value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_ranges(input int w, input int d);
      drain();
      csr_write(CSR_IDX_WORDS, w);
      csr_write(CSR_IDX_DOCS, d);
      words_now = (w > 256) ? 256 : w;
      docs_now  = (d > 64) ? 64 : d;
   endtask

   task automatic random_cmd(input int row_pool);
      int k;
      int a;
      int b;
      int cnt;
      k   = $urandom_range(0, 99);
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 40);
      if (k < 55) begin
         if (words_now == 0 || docs_now == 0 || $urandom_range(0, 19) == 0) begin
            cmd(FUNC_ADD, $urandom_range(0, 255), $urandom_range(0, 63), $urandom, cnt);
         end else begin
            a = (docs_now > 8 && $urandom_range(0, 1)) ? $urandom_range(0, 7)
                                                       : $urandom_range(0, docs_now - 1);
            cmd(FUNC_ADD, $urandom_range(0, (words_now < row_pool ? words_now : row_pool) - 1),
                a, $urandom, cnt);
         end
      end else if (k < 90) begin
         if (docs_now < 2 || $urandom_range(0, 9) == 0) begin
            cmd(FUNC_QUERY, $urandom, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
         end else begin
            a = $urandom_range(0, (docs_now > 8 ? 7 : docs_now - 1) - 1);
            b = $urandom_range(a + 1, docs_now > 8 ? 8 : docs_now - 1);
            cmd(FUNC_QUERY, $urandom, a, b, $urandom);
         end
      end else if (k < 94) begin
         cmd(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end else begin
         cmd(2'd3, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, saturation, order and range cases
      cmd(FUNC_ADD, 255, 63, 0, 65535);
      cmd(FUNC_ADD, 255, 63, 0, 65535);
      cmd(FUNC_ADD, 0, 0, 0, 0);
      cmd(FUNC_ADD, 0, 0, 0, 1);
      cmd(FUNC_ADD, 255, 0, 0, 7);
      cmd(FUNC_QUERY, 0, 0, 63, 0);
      cmd(FUNC_QUERY, 0, 63, 0, 0);
      cmd(FUNC_QUERY, 0, 5, 5, 0);
      cmd(FUNC_QUERY, 0, 1, 2, 0);
      cmd(2'd3, 255, 63, 63, 65535);
      cmd(FUNC_CLEAR, 0, 0, 0, 0);
      cmd(FUNC_QUERY, 0, 0, 63, 0);
      cmd(FUNC_ADD, 3, 1, 0, 100);
      cmd(FUNC_ADD, 3, 2, 0, 100);
      cmd(FUNC_QUERY, 0, 1, 2, 0);
      set_ranges(4, 8);
      cmd(FUNC_ADD, 4, 0, 0, 5);
      cmd(FUNC_ADD, 0, 8, 0, 5);
      cmd(FUNC_QUERY, 0, 2, 9, 0);
      cmd(FUNC_QUERY, 0, 1, 2, 0);
      set_ranges(0, 0);
      cmd(FUNC_ADD, 0, 0, 0, 1);
      cmd(FUNC_QUERY, 0, 0, 1, 0);
      set_ranges(511, 127);
      cmd(FUNC_QUERY, 0, 1, 2, 0);
      cmd(FUNC_ADD, 255, 63, 0, 1);

      // random phases over a spread of ranges, the last with no gaps
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: set_ranges($urandom_range(1, 16), $urandom_range(2, 8));
            1: set_ranges(1, 2);
            2: set_ranges(256, 64);
            3: set_ranges($urandom_range(2, 40), 1);
            4: set_ranges($urandom_range(1, 300), $urandom_range(1, 100));
            5: set_ranges(2, 64);
            default: begin
               set_ranges($urandom_range(4, 24), $urandom_range(3, 16));
               gaps_on = 1'b0;
            end
         endcase
         for (int i = 0; i < 43; i++) random_cmd(ph == 2 ? 32 : 256);
      end

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d adds, %0d queries, %0d clears, %0d commands in all",
               n_add, n_query, n_clear, sent);
      $display("register settings from zero to beyond the maximum, with and without gaps");
      if (fail_count == 0 && pending == 0) begin
         $display("doc_term_normalized_similarity_tb: PASS");
      end else begin
         $display("%0d mismatches, %0d results still awaited", fail_count, pending);
         $display("doc_term_normalized_similarity_tb: FAIL");
      end
      $finish;
   end

endmodule
